// ===== rtl/core/nsfc_pkg.sv =====
// nsfc_pkg: shared sizes, codes, types and lookup functions for the nmea sentence
// framer and checker. No dependencies; imported by every module of the block.
package nsfc_pkg;

  localparam int MAX_SENTENCE = 128;
  localparam int MAX_FIELDS   = 32;

  localparam int CNT_W   = $clog2(MAX_SENTENCE);
  localparam int FIELD_W = 6;
  localparam int STAT_W  = 16;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_CKSUM_BAD   = 3'd1;
  localparam logic [2:0] ST_FORMAT_BAD  = 3'd2;
  localparam logic [2:0] ST_FEW_FIELDS  = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  localparam logic [3:0] KIND_OTHER = 4'd0;
  localparam logic [3:0] KIND_GGA   = 4'd1;
  localparam logic [3:0] KIND_GLL   = 4'd2;
  localparam logic [3:0] KIND_GSA   = 4'd3;
  localparam logic [3:0] KIND_GSV   = 4'd4;
  localparam logic [3:0] KIND_RMC   = 4'd5;
  localparam logic [3:0] KIND_VTG   = 4'd6;
  localparam logic [3:0] KIND_ZDA   = 4'd7;
  localparam logic [3:0] KIND_TXT   = 4'd8;

  localparam logic [2:0] TALK_UNKNOWN = 3'd0;
  localparam logic [2:0] TALK_GPS     = 3'd1;
  localparam logic [2:0] TALK_GLONASS = 3'd2;
  localparam logic [2:0] TALK_GALILEO = 3'd3;
  localparam logic [2:0] TALK_BEIDOU  = 3'd4;
  localparam logic [2:0] TALK_QZSS    = 3'd5;
  localparam logic [2:0] TALK_NAVIC   = 3'd6;
  localparam logic [2:0] TALK_MIXED   = 3'd7;

  // summary of one finished sentence, framer to statistics
  typedef struct packed {
    logic               overflowed;
    logic [3:0]         kind;
    logic [2:0]         talker;
    logic               cksum_ok;
    logic               empty;
    logic               addr_ok;
    logic [FIELD_W-1:0] fields;
  } nsfc_sum_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         kind;
    logic [2:0]         talker;
    logic [FIELD_W-1:0] fields;
    logic [STAT_W-1:0]  received_total;
    logic [STAT_W-1:0]  valid_total;
    logic [STAT_W-1:0]  checksum_errors;
    logic [STAT_W-1:0]  parse_errors;
    logic [STAT_W-1:0]  unsupported_total;
    logic [7:0]         received_kinds;
    logic [7:0]         valid_kinds;
  } nsfc_res_t;

  function automatic logic [3:0] kind_decode(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
    logic [23:0] t;
    t = {a, b, c};
    case (t)
      "GGA":   kind_decode = KIND_GGA;
      "GLL":   kind_decode = KIND_GLL;
      "GSA":   kind_decode = KIND_GSA;
      "GSV":   kind_decode = KIND_GSV;
      "RMC":   kind_decode = KIND_RMC;
      "VTG":   kind_decode = KIND_VTG;
      "ZDA":   kind_decode = KIND_ZDA;
      "TXT":   kind_decode = KIND_TXT;
      default: kind_decode = KIND_OTHER;
    endcase
  endfunction

  function automatic logic [2:0] talker_decode(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] t;
    t = {a, b};
    case (t)
      "GP":    talker_decode = TALK_GPS;
      "BD":    talker_decode = TALK_BEIDOU;
      "GB":    talker_decode = TALK_BEIDOU;
      "GL":    talker_decode = TALK_GLONASS;
      "GA":    talker_decode = TALK_GALILEO;
      "GQ":    talker_decode = TALK_QZSS;
      "GI":    talker_decode = TALK_NAVIC;
      "GN":    talker_decode = TALK_MIXED;
      default: talker_decode = TALK_UNKNOWN;
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] kind_min_fields(input logic [3:0] kind);
    case (kind)
      KIND_GGA: kind_min_fields = FIELD_W'(15);
      KIND_GLL: kind_min_fields = FIELD_W'(7);
      KIND_GSA: kind_min_fields = FIELD_W'(18);
      KIND_GSV: kind_min_fields = FIELD_W'(4);
      KIND_RMC: kind_min_fields = FIELD_W'(12);
      KIND_VTG: kind_min_fields = FIELD_W'(9);
      KIND_ZDA: kind_min_fields = FIELD_W'(7);
      KIND_TXT: kind_min_fields = FIELD_W'(5);
      default:  kind_min_fields = FIELD_W'(0);
    endcase
  endfunction

endpackage

// ===== rtl/core/nsfc_framer.sv =====
// nsfc_framer: per-byte sentence state (framing, checksum, address, field count).
// Depends on nsfc_pkg; produces an nsfc_sum_t when a sentence closes.
module nsfc_framer
  import nsfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output logic       sent_end,
  output nsfc_sum_t  sum
);

  logic               collecting_r, collecting_nxt;
  logic [CNT_W-1:0]   char_count_r, char_count_nxt;
  logic               overflowed_r, overflowed_nxt;
  logic [7:0]         xor_r, xor_nxt;
  logic               star_seen_r, star_seen_nxt;
  logic [1:0]         asc_r, asc_nxt;
  logic [7:0]         given_r, given_nxt;
  logic               hex_bad_r, hex_bad_nxt;
  logic [7:0]         head_r [5];
  logic [7:0]         head_nxt [5];
  logic [2:0]         alen_r, alen_nxt;
  logic               comma_seen_r, comma_seen_nxt;
  logic [FIELD_W-1:0] comma_total_r, comma_total_nxt;

  logic       is_hex;
  logic [3:0] hex_val;
  logic       is_end;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (rx_byte >= "0" && rx_byte <= "9") begin
      hex_val = 4'(rx_byte - "0");
    end else if (rx_byte >= "A" && rx_byte <= "F") begin
      hex_val = 4'(rx_byte - "A" + 8'd10);
    end else if (rx_byte >= "a" && rx_byte <= "f") begin
      hex_val = 4'(rx_byte - "a" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_end = (rx_byte == CH_CR) || (rx_byte == CH_LF);

  // sentence closes with a result when it overflowed or holds payload
  assign sent_end = step && collecting_r && (rx_byte != CH_DOLLAR) && is_end &&
                    (overflowed_r || char_count_r > CNT_W'(1));

  always_comb begin
    sum.overflowed = overflowed_r;
    sum.kind       = (char_count_r >= CNT_W'(6)) ?
                     kind_decode(head_r[2], head_r[3], head_r[4]) : KIND_OTHER;
    sum.talker     = (char_count_r >= CNT_W'(3)) ?
                     talker_decode(head_r[0], head_r[1]) : TALK_UNKNOWN;
    sum.cksum_ok   = star_seen_r && (asc_r == 2'd2) && !hex_bad_r && (xor_r == given_r);
    sum.empty      = (alen_r == 3'd0) && !comma_seen_r;
    sum.addr_ok    = (alen_r == 3'd5);
    sum.fields     = comma_total_r + FIELD_W'(1);
  end

  always_comb begin
    collecting_nxt  = collecting_r;
    char_count_nxt  = char_count_r;
    overflowed_nxt  = overflowed_r;
    xor_nxt         = xor_r;
    star_seen_nxt   = star_seen_r;
    asc_nxt         = asc_r;
    given_nxt       = given_r;
    hex_bad_nxt     = hex_bad_r;
    head_nxt        = head_r;
    alen_nxt        = alen_r;
    comma_seen_nxt  = comma_seen_r;
    comma_total_nxt = comma_total_r;
    if (step) begin
      if (rx_byte == CH_DOLLAR) begin
        collecting_nxt  = 1'b1;
        char_count_nxt  = CNT_W'(1);
        overflowed_nxt  = 1'b0;
        xor_nxt         = 8'd0;
        star_seen_nxt   = 1'b0;
        asc_nxt         = 2'd0;
        given_nxt       = 8'd0;
        hex_bad_nxt     = 1'b0;
        for (int i = 0; i < 5; i++) head_nxt[i] = 8'd0;
        alen_nxt        = 3'd0;
        comma_seen_nxt  = 1'b0;
        comma_total_nxt = '0;
      end else if (collecting_r) begin
        if (is_end) begin
          collecting_nxt = 1'b0;
          char_count_nxt = '0;
        end else if (char_count_r < CNT_W'(MAX_SENTENCE - 1)) begin
          for (int i = 0; i < 5; i++) begin
            if (char_count_r == CNT_W'(i + 1)) head_nxt[i] = rx_byte;
          end
          char_count_nxt = char_count_r + CNT_W'(1);
          if (star_seen_r) begin
            if (asc_r < 2'd2) begin
              if (!is_hex) hex_bad_nxt = 1'b1;
              else given_nxt = {given_r[3:0], hex_val};
            end
            if (asc_r != 2'd3) asc_nxt = asc_r + 2'd1;
          end else if (rx_byte == CH_STAR) begin
            star_seen_nxt = 1'b1;
          end else begin
            xor_nxt = xor_r ^ rx_byte;
            if (rx_byte == CH_COMMA) begin
              comma_seen_nxt = 1'b1;
              if (comma_total_r < FIELD_W'(MAX_FIELDS - 1)) begin
                comma_total_nxt = comma_total_r + FIELD_W'(1);
              end
            end else if (!comma_seen_r && alen_r < 3'd6) begin
              alen_nxt = alen_r + 3'd1;
            end
          end
        end else begin
          overflowed_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r  <= 1'b0;
      char_count_r  <= '0;
      overflowed_r  <= 1'b0;
      xor_r         <= 8'd0;
      star_seen_r   <= 1'b0;
      asc_r         <= 2'd0;
      given_r       <= 8'd0;
      hex_bad_r     <= 1'b0;
      for (int i = 0; i < 5; i++) head_r[i] <= 8'd0;
      alen_r        <= 3'd0;
      comma_seen_r  <= 1'b0;
      comma_total_r <= '0;
    end else begin
      collecting_r  <= collecting_nxt;
      char_count_r  <= char_count_nxt;
      overflowed_r  <= overflowed_nxt;
      xor_r         <= xor_nxt;
      star_seen_r   <= star_seen_nxt;
      asc_r         <= asc_nxt;
      given_r       <= given_nxt;
      hex_bad_r     <= hex_bad_nxt;
      head_r        <= head_nxt;
      alen_r        <= alen_nxt;
      comma_seen_r  <= comma_seen_nxt;
      comma_total_r <= comma_total_nxt;
    end
  end

endmodule

// ===== rtl/core/nsfc_stats.sv =====
// nsfc_stats: classifies a finished sentence, keeps saturating counters and type masks.
// Depends on nsfc_pkg; takes an nsfc_sum_t and builds the nsfc_res_t of that sentence.
module nsfc_stats
  import nsfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  nsfc_sum_t sum,
  output nsfc_res_t res
);

  logic [STAT_W-1:0] cnt_r [5];
  logic [STAT_W-1:0] cnt_nxt [5];
  logic [7:0]        rmask_r, rmask_nxt;
  logic [7:0]        vmask_r, vmask_nxt;
  logic [4:0]        bump;
  logic [7:0]        kbit;
  logic [2:0]        status;
  logic [FIELD_W-1:0] fields;
  logic [3:0]        kind;
  logic [2:0]        talker;

  // bump bits: 0 received, 1 valid, 2 checksum, 3 parse, 4 unsupported
  always_comb begin
    bump      = 5'b0;
    status    = ST_OK;
    fields    = '0;
    kind      = KIND_OTHER;
    talker    = TALK_UNKNOWN;
    kbit      = 8'd0;
    rmask_nxt = rmask_r;
    vmask_nxt = vmask_r;
    if (sum.overflowed) begin
      bump[0] = 1'b1;
      bump[3] = 1'b1;
      status  = ST_FORMAT_BAD;
    end else begin
      kind   = sum.kind;
      talker = sum.talker;
      if (sum.kind != KIND_OTHER) kbit = 8'b1 << (sum.kind - 4'd1);
      rmask_nxt = rmask_r | kbit;
      if (!sum.cksum_ok) begin
        bump[0] = 1'b1;
        bump[2] = 1'b1;
        status  = ST_CKSUM_BAD;
      end else if (sum.empty) begin
        bump[3] = 1'b1;
        status  = ST_FORMAT_BAD;
      end else begin
        fields = sum.fields;
        if (!sum.addr_ok) begin
          bump[3] = 1'b1;
          status  = ST_FORMAT_BAD;
        end else begin
          bump[0]   = 1'b1;
          bump[1]   = 1'b1;
          vmask_nxt = vmask_r | kbit;
          if (sum.kind == KIND_OTHER) begin
            bump[4] = 1'b1;
            status  = ST_UNSUPPORTED;
          end else if (sum.fields < kind_min_fields(sum.kind)) begin
            bump[3] = 1'b1;
            status  = ST_FEW_FIELDS;
          end
        end
      end
    end
    for (int i = 0; i < 5; i++) begin
      cnt_nxt[i] = (bump[i] && cnt_r[i] != {STAT_W{1'b1}}) ?
                   cnt_r[i] + STAT_W'(1) : cnt_r[i];
    end
  end

  always_comb begin
    res.status            = status;
    res.kind              = kind;
    res.talker            = talker;
    res.fields            = fields;
    res.received_total    = cnt_nxt[0];
    res.valid_total       = cnt_nxt[1];
    res.checksum_errors   = cnt_nxt[2];
    res.parse_errors      = cnt_nxt[3];
    res.unsupported_total = cnt_nxt[4];
    res.received_kinds    = rmask_nxt;
    res.valid_kinds       = vmask_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) cnt_r[i] <= '0;
      rmask_r <= 8'd0;
      vmask_r <= 8'd0;
    end else if (fire) begin
      cnt_r   <= cnt_nxt;
      rmask_r <= rmask_nxt;
      vmask_r <= vmask_nxt;
    end
  end

endmodule

// ===== rtl/core/nmea_sentence_framer_checker.sv =====
// nmea_sentence_framer_checker: top level, input register, framer, statistics, result register.
// Depends on nsfc_pkg, nsfc_framer and nsfc_stats.
//
// Takes one NMEA 0183 character per input transaction. A '$' opens a sentence and a CR or
// LF closes it; every closed, non-empty sentence yields one result transaction carrying
// status, sentence kind, constellation, field count, five saturating 16-bit counters and
// two seen-type masks. Bytes outside a sentence and a bare '$' followed by CR/LF give no
// result; a second '$' drops the open sentence silently. Throughput is one character per
// clock unless the output stalls: the byte sits in the input register, the framer updates its
// sentence state from it, and on CR/LF the statistics logic classifies the sentence and the
// result is written to the output register in that same cycle; a result is valid once its
// closing character has passed both registers. While a result waits unread, the character in
// the input register is held and the input side stalls; the input register drains whenever
// the output register is free or being read. There are no configuration registers and no
// memories; all sentence state and counters reset at once, payload registers need no reset.
module nmea_sentence_framer_checker
  import nsfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [3:0]         out_sentence_kind,
  output logic [2:0]         out_constellation,
  output logic [FIELD_W-1:0] out_field_total,
  output logic [STAT_W-1:0]  out_received_total,
  output logic [STAT_W-1:0]  out_valid_total,
  output logic [STAT_W-1:0]  out_checksum_errors,
  output logic [STAT_W-1:0]  out_parse_errors,
  output logic [STAT_W-1:0]  out_unsupported_total,
  output logic [7:0]         out_received_kinds,
  output logic [7:0]         out_valid_kinds
);

  // input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;

  // result register
  logic       out_valid_r, out_valid_nxt;
  nsfc_res_t  out_res_r;

  logic       advance;   // output side can take whatever this byte produces
  logic       step;      // byte in the input register is processed this cycle
  logic       sent_end;  // this byte closes a sentence with a result
  logic       fire;
  nsfc_sum_t  sum;
  nsfc_res_t  res;

  assign advance  = !out_valid_r || out_ready;
  assign step     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;
  assign fire     = sent_end;

  always_comb begin
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_rx_byte;
    if (fire) out_res_r <= res;
  end

  nsfc_framer u_framer (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_byte  (in_byte_r),
    .sent_end (sent_end),
    .sum      (sum)
  );

  nsfc_stats u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .sum   (sum),
    .res   (res)
  );

  assign out_valid             = out_valid_r;
  assign out_status            = out_res_r.status;
  assign out_sentence_kind     = out_res_r.kind;
  assign out_constellation     = out_res_r.talker;
  assign out_field_total       = out_res_r.fields;
  assign out_received_total    = out_res_r.received_total;
  assign out_valid_total       = out_res_r.valid_total;
  assign out_checksum_errors   = out_res_r.checksum_errors;
  assign out_parse_errors      = out_res_r.parse_errors;
  assign out_unsupported_total = out_res_r.unsupported_total;
  assign out_received_kinds    = out_res_r.received_kinds;
  assign out_valid_kinds       = out_res_r.valid_kinds;

endmodule

// ===== rtl/core/nsfc_checker.sv =====
// nsfc_checker: port-level assertions for nmea_sentence_framer_checker, bound to the top.
// Depends on nsfc_pkg.
module nsfc_checker
  import nsfc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic [3:0]         out_sentence_kind,
  input logic [2:0]         out_constellation,
  input logic [FIELD_W-1:0] out_field_total,
  input logic [STAT_W-1:0]  out_received_total,
  input logic [STAT_W-1:0]  out_valid_total,
  input logic [STAT_W-1:0]  out_checksum_errors,
  input logic [STAT_W-1:0]  out_parse_errors,
  input logic [STAT_W-1:0]  out_unsupported_total,
  input logic [7:0]         out_received_kinds,
  input logic [7:0]         out_valid_kinds
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_sentence_kind) && $stable(out_constellation) &&
    $stable(out_received_total) && $stable(out_parse_errors))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an accepted sentence has a known kind, a field count, a valid total and valid types within the received types
  a_ok_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |->
      out_sentence_kind != KIND_OTHER && out_field_total != '0 &&
      out_valid_total != '0 && (out_valid_kinds & ~out_received_kinds) == 8'd0)
    else $error("accepted sentence with inconsistent fields");

  // checksum failures and unsupported types report as the classification defines
  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_status != ST_CKSUM_BAD || (out_field_total == '0 && out_checksum_errors != '0)) &&
      (out_status != ST_UNSUPPORTED ||
       (out_sentence_kind == KIND_OTHER && out_unsupported_total != '0)))
    else $error("status does not match reported fields");

endmodule

bind nmea_sentence_framer_checker nsfc_checker u_nsfc_checker (.*);

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for nmea_sentence_framer_checker, one character per transaction.
// Depends on nsfc_pkg for sizes and codes; an internal sentence tracker predicts each result.

module tb_top;
  import nsfc_pkg::*;

  // ----------------------------------------------------------------------------------------
  // clock, reset and the ports of the block
  // ----------------------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status;
  logic [3:0]         out_sentence_kind;
  logic [2:0]         out_constellation;
  logic [FIELD_W-1:0] out_field_total;
  logic [STAT_W-1:0]  out_received_total;
  logic [STAT_W-1:0]  out_valid_total;
  logic [STAT_W-1:0]  out_checksum_errors;
  logic [STAT_W-1:0]  out_parse_errors;
  logic [STAT_W-1:0]  out_unsupported_total;
  logic [7:0]         out_received_kinds;
  logic [7:0]         out_valid_kinds;

  nmea_sentence_framer_checker dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_sentence_kind    (out_sentence_kind),
    .out_constellation    (out_constellation),
    .out_field_total      (out_field_total),
    .out_received_total   (out_received_total),
    .out_valid_total      (out_valid_total),
    .out_checksum_errors  (out_checksum_errors),
    .out_parse_errors     (out_parse_errors),
    .out_unsupported_total(out_unsupported_total),
    .out_received_kinds   (out_received_kinds),
    .out_valid_kinds      (out_valid_kinds)
  );

  // ----------------------------------------------------------------------------------------
  // tables for the stimulus; the kind tags and minimum field counts also serve the tracker
  // ----------------------------------------------------------------------------------------
  // sentence type tags in kind order, bit 0 of the masks is the first one
  logic [23:0] kind_tags [8] = '{"GGA", "GLL", "GSA", "GSV", "RMC", "VTG", "ZDA", "TXT"};
  int          kind_floor[8] = '{15, 7, 18, 4, 12, 9, 7, 5};
  logic [15:0] talk_ids  [8] = '{"GP", "GL", "GA", "BD", "GB", "GQ", "GI", "GN"};

  localparam int HOLD_START = 400;   // cycles after reset before the long receiver hold-off
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN      = 20;    // quiet cycles after the last result, well over latency
  localparam int RUN_CHARS  = 650;   // minimum number of characters queued for the whole run

  typedef enum int {
    CK_GOOD, CK_LOWER, CK_WRONG, CK_NONE, CK_ONE_DIGIT, CK_THREE_DIGITS, CK_NOT_HEX
  } ck_style_e;

  logic [7:0] char_q[$];     // characters waiting to be sent
  logic [7:0] line_buf[$];   // payload of the sentence under construction
  nsfc_res_t  result_q[$];   // predicted results, oldest first
  int         n_lines;
  int         n_errors;
  int         n_results;
  int         n_fed;
  int         n_stalls;
  int         status_seen[5];

  // ----------------------------------------------------------------------------------------
  // sentence tracker: mirrors the framing, checksum and statistics rules
  // ----------------------------------------------------------------------------------------
  logic        in_frame = 1'b0;
  int          kept_n = 0;          // characters kept, counting the dollar
  logic        frame_ovf = 1'b0;
  logic [7:0]  xsum = 8'h00;
  logic        star_hit = 1'b0;
  int          post_star_n = 0;     // characters after the star, stops at 3
  logic [7:0]  sum_given = 8'h00;
  logic        bad_hex = 1'b0;
  logic [7:0]  head_buf[5] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  int          addr_n = 0;          // address length, stops at 6
  logic        comma_hit = 1'b0;
  int          comma_n = 0;         // stops at MAX_FIELDS-1
  logic [15:0] n_received = '0;
  logic [15:0] n_valid = '0;
  logic [15:0] n_cksum_err = '0;
  logic [15:0] n_parse_err = '0;
  logic [15:0] n_unsupported = '0;
  logic [7:0]  seen_kinds = '0;
  logic [7:0]  good_kinds = '0;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  task automatic open_frame();
    in_frame    = 1'b1;
    kept_n      = 1;
    frame_ovf   = 1'b0;
    xsum        = 8'h00;
    star_hit    = 1'b0;
    post_star_n = 0;
    sum_given   = 8'h00;
    bad_hex     = 1'b0;
    foreach (head_buf[i]) head_buf[i] = 8'h00;
    addr_n      = 0;
    comma_hit   = 1'b0;
    comma_n     = 0;
  endtask

  task automatic absorb_char(input logic [7:0] c);
    int v;
    if (kept_n - 1 < 5) head_buf[kept_n - 1] = c;
    kept_n++;
    if (star_hit) begin
      // only the first two characters after the star form the checksum
      if (post_star_n < 2) begin
        v = hex_val(c);
        if (v < 0) bad_hex = 1'b1;
        else sum_given = {sum_given[3:0], 4'(v)};
      end
      if (post_star_n < 3) post_star_n++;
    end else if (c == CH_STAR) begin
      star_hit = 1'b1;
    end else begin
      xsum ^= c;
      if (c == CH_COMMA) begin
        comma_hit = 1'b1;
        if (comma_n < MAX_FIELDS - 1) comma_n++;
      end else if (!comma_hit && addr_n < 6) begin
        addr_n++;
      end
    end
  endtask

  task automatic close_frame();
    nsfc_res_t   r;
    logic [7:0]  kbit;
    logic [15:0] pair;
    int          k;
    r = '0;
    r.status = ST_OK;
    r.kind   = KIND_OTHER;
    r.talker = TALK_UNKNOWN;
    kbit     = 8'h00;
    if (frame_ovf) begin
      n_received  = sat_inc(n_received);
      n_parse_err = sat_inc(n_parse_err);
      r.status    = ST_FORMAT_BAD;
    end else begin
      // type from payload characters 2..4, talker from 0..1
      if (kept_n >= 6) begin
        for (k = 0; k < 8; k++) begin
          if ({head_buf[2], head_buf[3], head_buf[4]} == kind_tags[k]) r.kind = KIND_GGA + 4'(k);
        end
      end
      if (kept_n >= 3) begin
        pair = {head_buf[0], head_buf[1]};
        if (pair == "GP") r.talker = TALK_GPS;
        else if (pair == "BD" || pair == "GB") r.talker = TALK_BEIDOU;
        else if (pair == "GL") r.talker = TALK_GLONASS;
        else if (pair == "GA") r.talker = TALK_GALILEO;
        else if (pair == "GQ") r.talker = TALK_QZSS;
        else if (pair == "GI") r.talker = TALK_NAVIC;
        else if (pair == "GN") r.talker = TALK_MIXED;
      end
      if (r.kind != KIND_OTHER) kbit = 8'h01 << (r.kind - KIND_GGA);
      seen_kinds |= kbit;
      if (!star_hit || post_star_n != 2 || bad_hex || xsum != sum_given) begin
        n_received  = sat_inc(n_received);
        n_cksum_err = sat_inc(n_cksum_err);
        r.status    = ST_CKSUM_BAD;
      end else if (addr_n == 0 && !comma_hit) begin
        // nothing between the dollar and the star
        n_parse_err = sat_inc(n_parse_err);
        r.status    = ST_FORMAT_BAD;
      end else begin
        r.fields = FIELD_W'(comma_n + 1);
        if (addr_n != 5) begin
          n_parse_err = sat_inc(n_parse_err);
          r.status    = ST_FORMAT_BAD;
        end else begin
          n_received = sat_inc(n_received);
          n_valid    = sat_inc(n_valid);
          good_kinds |= kbit;
          if (r.kind == KIND_OTHER) begin
            n_unsupported = sat_inc(n_unsupported);
            r.status      = ST_UNSUPPORTED;
          end else if (comma_n + 1 < kind_floor[r.kind - KIND_GGA]) begin
            n_parse_err = sat_inc(n_parse_err);
            r.status    = ST_FEW_FIELDS;
          end
        end
      end
    end
    r.received_total    = n_received;
    r.valid_total       = n_valid;
    r.checksum_errors   = n_cksum_err;
    r.parse_errors      = n_parse_err;
    r.unsupported_total = n_unsupported;
    r.received_kinds    = seen_kinds;
    r.valid_kinds       = good_kinds;
    status_seen[r.status]++;
    result_q.push_back(r);
  endtask

  task automatic track_char(input logic [7:0] c);
    if (c == CH_DOLLAR) begin
      open_frame();   // also drops any open sentence
    end else if (in_frame) begin
      if (c == CH_CR || c == CH_LF) begin
        if (frame_ovf || kept_n > 1) close_frame();
        in_frame = 1'b0;
        kept_n   = 0;
      end else if (kept_n < MAX_SENTENCE - 1) begin
        absorb_char(c);
      end else begin
        frame_ovf = 1'b1;
      end
    end
  endtask

  // ----------------------------------------------------------------------------------------
  // sentence builders feeding char_q
  // ----------------------------------------------------------------------------------------
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    // mostly printable text, sometimes any byte value including zero
    do begin
      if ($urandom_range(0, 5) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(32, 126));
    end while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA || c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower_case);
    if (n < 4'd10) return 8'("0" + n);
    return lower_case ? 8'("a" + n - 10) : 8'("A" + n - 10);
  endfunction

  function automatic logic [7:0] upper_char();
    return 8'($urandom_range(65, 90));
  endfunction

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic put_raw(input string s);
    int i;
    for (i = 0; i < s.len(); i++) char_q.push_back(s[i]);
  endtask

  // adds n_fields-1 commas with short random fields, pads, then dollar, payload, checksum, eol
  task automatic seal_line(input int n_fields, input ck_style_e style, input int pad);
    logic [7:0] sum;
    logic [7:0] bogus;
    int         i;
    for (i = 1; i < n_fields; i++) begin
      line_buf.push_back(CH_COMMA);
      repeat ($urandom_range(0, 2)) line_buf.push_back(field_char());
    end
    while (pad > 0 && line_buf.size() < pad) line_buf.push_back(field_char());
    sum = 8'h00;
    for (i = 0; i < line_buf.size(); i++) sum ^= line_buf[i];
    char_q.push_back(CH_DOLLAR);
    while (line_buf.size() != 0) char_q.push_back(line_buf.pop_front());
    if (style != CK_NONE) char_q.push_back(CH_STAR);
    case (style)
      CK_GOOD, CK_LOWER, CK_THREE_DIGITS: begin
        char_q.push_back(hex_char(sum[7:4], style == CK_LOWER));
        char_q.push_back(hex_char(sum[3:0], style == CK_LOWER));
        if (style == CK_THREE_DIGITS) char_q.push_back(hex_char(4'($urandom_range(0, 15)), 0));
      end
      CK_WRONG: begin
        bogus = sum ^ 8'($urandom_range(1, 255));
        char_q.push_back(hex_char(bogus[7:4], 0));
        char_q.push_back(hex_char(bogus[3:0], 0));
      end
      CK_ONE_DIGIT: char_q.push_back(hex_char(sum[7:4], 0));
      CK_NOT_HEX: begin
        if ($urandom_range(0, 1) == 0) begin
          char_q.push_back("G");
          char_q.push_back(hex_char(sum[3:0], 0));
        end else begin
          char_q.push_back(hex_char(sum[7:4], 0));
          char_q.push_back("z");
        end
      end
      default: ;
    endcase
    case ($urandom_range(0, 2))
      0: char_q.push_back(CH_CR);
      1: char_q.push_back(CH_LF);
      default: begin
        char_q.push_back(CH_CR);
        char_q.push_back(CH_LF);   // lands outside the sentence
      end
    endcase
    n_lines++;
  endtask

  // talker plus type; k comes back 0..7 for a known tag, 8 for random letters
  task automatic put_address(output int k);
    logic [15:0] t;
    logic [23:0] g;
    if ($urandom_range(0, 9) != 0) begin
      t = talk_ids[$urandom_range(0, 7)];
      line_buf.push_back(t[15:8]);
      line_buf.push_back(t[7:0]);
    end else begin
      line_buf.push_back(upper_char());
      line_buf.push_back(upper_char());
    end
    k = $urandom_range(0, 8);
    if (k < 8) begin
      g = kind_tags[k];
      line_buf.push_back(g[23:16]);
      line_buf.push_back(g[15:8]);
      line_buf.push_back(g[7:0]);
    end else begin
      repeat (3) line_buf.push_back(upper_char());
    end
  endtask

  task automatic add_sentence(input ck_style_e style, input bit wide);
    int k;
    int n;
    put_address(k);
    if (wide) n = $urandom_range(28, 45);
    else if (k == 8) n = $urandom_range(1, 12);
    else begin
      // straddle the minimum field count of the type
      case ($urandom_range(0, 3))
        0: n = kind_floor[k] - 1;
        1: n = kind_floor[k];
        default: n = kind_floor[k] + $urandom_range(0, 6);
      endcase
    end
    seal_line(n, style, 0);
  endtask

  function automatic ck_style_e broken_style();
    case ($urandom_range(0, 4))
      0: return CK_WRONG;
      1: return CK_NONE;
      2: return CK_ONE_DIGIT;
      3: return CK_THREE_DIGITS;
      default: return CK_NOT_HEX;
    endcase
  endfunction

  // ----------------------------------------------------------------------------------------
  // driver: one character per transaction, random gap after each
  // ----------------------------------------------------------------------------------------
  logic [7:0] fed_char = 8'h00;
  logic       fed = 1'b0;
  int         tx_wait = 0;

  always @(posedge clk) begin : char_driver
    int offered;
    bit lazy;
    if (!rst_n) begin
      in_valid <= 1'b0;
      fed      <= 1'b0;
      tx_wait  <= 0;
    end else begin
      fed      <= in_valid && in_ready;
      fed_char <= in_rx_byte;
      if (in_valid && !in_ready) n_stalls++;
      // a pending transaction keeps valid and payload as they are
      if (!in_valid || in_ready) begin
        if (tx_wait != 0) begin
          tx_wait  <= tx_wait - 1;
          in_valid <= 1'b0;
        end else if (char_q.size() != 0) begin
          if (offered % 40 == 0) lazy = $urandom_range(0, 1);
          offered++;
          in_valid   <= 1'b1;
          in_rx_byte <= char_q.pop_front();
          tx_wait    <= lazy ? $urandom_range(0, 5) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // tracking on the falling edge keeps the expectation queue out of the
  // rising-edge race with the monitor
  always @(negedge clk) begin
    if (fed) begin
      n_fed++;
      track_char(fed_char);
    end
  end

  // ----------------------------------------------------------------------------------------
  // long receiver hold-off, counted in its own process, so the block backs up
  // ----------------------------------------------------------------------------------------
  int   cyc = 0;
  logic rx_hold = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      cyc     <= 0;
      rx_hold <= 1'b0;
    end else begin
      cyc     <= cyc + 1;
      rx_hold <= (cyc >= HOLD_START) && (cyc < HOLD_START + HOLD_LEN);
    end
  end

  // ----------------------------------------------------------------------------------------
  // monitor: takes result transactions and compares them with the oldest prediction
  // ----------------------------------------------------------------------------------------
  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    // print a bounded number of lines, keep counting
    if (n_errors < 60)
      $display("ERROR: result %0d %s: got %0d, want %0d", n_results, what, got, want);
    n_errors++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report(what, got, want);
  endtask

  int rx_wait = 0;

  always @(posedge clk) begin : result_monitor
    nsfc_res_t want;
    int        w;
    bit        lazy;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else begin
      w = rx_wait;
      if (out_valid && out_ready) begin
        n_results++;
        if (result_q.size() == 0) begin
          report("arrived with nothing predicted", 16'(out_status), 16'hFFFF);
        end else begin
          want = result_q.pop_front();
          check_field("status", 16'(out_status), 16'(want.status));
          check_field("sentence_kind", 16'(out_sentence_kind), 16'(want.kind));
          check_field("constellation", 16'(out_constellation), 16'(want.talker));
          check_field("field_total", 16'(out_field_total), 16'(want.fields));
          check_field("received_total", out_received_total, want.received_total);
          check_field("valid_total", out_valid_total, want.valid_total);
          check_field("checksum_errors", out_checksum_errors, want.checksum_errors);
          check_field("parse_errors", out_parse_errors, want.parse_errors);
          check_field("unsupported_total", out_unsupported_total, want.unsupported_total);
          check_field("received_kinds", 16'(out_received_kinds), 16'(want.received_kinds));
          check_field("valid_kinds", 16'(out_valid_kinds), 16'(want.valid_kinds));
        end
        if (n_results % 16 == 1) lazy = $urandom_range(0, 1);
        w = lazy ? $urandom_range(0, 5) : 0;
      end
      out_ready <= !rx_hold && (w == 0);
      rx_wait   <= (w == 0) ? 0 : w - 1;
    end
  end

  // ----------------------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ----------------------------------------------------------------------------------------
  initial begin : stimulus
    int spin;
    int r;
    int k;
    int len;

    // bytes outside any sentence, both extremes of the byte
    char_q.push_back(8'h00);
    char_q.push_back(8'hFF);
    char_q.push_back("A");
    // dollar straight into a line end gives nothing
    char_q.push_back(CH_DOLLAR);
    char_q.push_back(CH_CR);
    // every known type at its minimum, every talker
    put_text("GPGGA"); seal_line(15, CK_GOOD, 0);
    put_text("GLGLL"); seal_line(7, CK_GOOD, 0);
    put_text("GAGSA"); seal_line(18, CK_GOOD, 0);
    put_text("BDGSV"); seal_line(4, CK_GOOD, 0);
    put_text("GBRMC"); seal_line(12, CK_GOOD, 0);
    put_text("GQVTG"); seal_line(9, CK_GOOD, 0);
    put_text("GIZDA"); seal_line(7, CK_GOOD, 0);
    put_text("GNTXT"); seal_line(5, CK_GOOD, 0);
    // one field short of the minimum
    put_text("GNGSV"); seal_line(3, CK_GOOD, 0);
    // unknown type, unknown talker with lower-case hex
    put_text("GPXYZ"); seal_line(2, CK_GOOD, 0);
    put_text("ABGSV"); seal_line(4, CK_LOWER, 0);
    // each way a checksum can be bad
    put_text("GPGSV"); seal_line(1, CK_WRONG, 0);
    put_text("GPGSV"); seal_line(1, CK_NONE, 0);
    put_text("GPGSV"); seal_line(1, CK_ONE_DIGIT, 0);
    put_text("GPGSV"); seal_line(1, CK_THREE_DIGITS, 0);
    put_text("GPGSV"); seal_line(1, CK_NOT_HEX, 0);
    // address too short and too long
    put_text("GPGG"); seal_line(2, CK_GOOD, 0);
    put_text("GPGSVX"); seal_line(1, CK_GOOD, 0);
    // empty payload, payload that is only fields, payload too short for a talker
    seal_line(1, CK_GOOD, 0);
    seal_line(2, CK_GOOD, 0);
    put_text("G"); seal_line(1, CK_GOOD, 0);
    // a second dollar drops the open sentence
    put_raw("$GPGGA,12");
    put_text("GPGSV"); seal_line(4, CK_GOOD, 0);
    // longest sentence that fits, with a field count above the cap, then one character more
    put_text("GPTXT"); seal_line(34, CK_GOOD, MAX_SENTENCE - 5);
    put_text("GPTXT"); seal_line(5, CK_GOOD, MAX_SENTENCE - 4);

    // random part tops the run up: mostly well-formed sentences, the rest broken ones and noise
    while (char_q.size() < RUN_CHARS) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        add_sentence(CK_GOOD, 0);
      end else if (r < 60) begin
        add_sentence(CK_LOWER, 0);
      end else if (r < 68) begin
        add_sentence(broken_style(), 0);
      end else if (r < 74) begin
        // address length anything but five
        do len = $urandom_range(0, 7); while (len == 5);
        repeat (len) line_buf.push_back(upper_char());
        seal_line($urandom_range(1, 8), CK_GOOD, 0);
      end else if (r < 78) begin
        repeat ($urandom_range(1, 8)) char_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 82) begin
        char_q.push_back(CH_DOLLAR);
        repeat ($urandom_range(0, 12)) char_q.push_back(field_char());
        add_sentence(CK_GOOD, 0);
      end else if (r < 85) begin
        put_address(k);
        seal_line(5, CK_GOOD, $urandom_range(110, 140));
      end else if (r < 89) begin
        case ($urandom_range(0, 2))
          0: begin
            char_q.push_back(CH_DOLLAR);
            char_q.push_back(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
          end
          1: seal_line(1, CK_GOOD, 0);
          default: seal_line($urandom_range(2, 4), CK_GOOD, 0);
        endcase
      end else begin
        add_sentence(CK_GOOD, 1);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // every character accepted, then every prediction met, then a quiet stretch
    while (char_q.size() != 0 || in_valid) @(posedge clk);
    for (spin = 0; result_q.size() != 0 && spin < 20000; spin++) @(posedge clk);
    if (result_q.size() != 0) report("predictions never met", 16'(result_q.size()), 16'd0);
    repeat (DRAIN) @(posedge clk);

    $write("summary: %0d characters, %0d results ", n_fed, n_results);
    $display("(ok %0d, checksum %0d, format %0d, few fields %0d, unsupported %0d)",
             status_seen[ST_OK], status_seen[ST_CKSUM_BAD], status_seen[ST_FORMAT_BAD],
             status_seen[ST_FEW_FIELDS], status_seen[ST_UNSUPPORTED]);
    $display("summary: receiver held off %0d cycles once, input stalled %0d cycles in all",
             HOLD_LEN, n_stalls);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/nsfc_pkg.sv
rtl/core/nsfc_framer.sv
rtl/core/nsfc_stats.sv
rtl/core/nmea_sentence_framer_checker.sv
rtl/core/nsfc_checker.sv
tb/tb_top.sv
